// ----- rtl/csa_pkg.sv -----
// Shared constants and types of the completion slot allocator.
package csa_pkg;

   // Slots usable in each bank; slot numbering always spans BANK_SPAN per bank.
   localparam int SLOTS_PER_BANK_DEFAULT = 64;
   localparam int BANK_SPAN              = 64;
   localparam int OFFSET_W               = 6;   // log2 of BANK_SPAN
   localparam int ENTRY_SHIFT            = 6;   // 64-byte entries

   localparam int SLOT_W  = 7;
   localparam int ADDR_W  = 64;
   localparam int DATA_W  = 64;
   localparam int PADDR_W = 5;

   // Request codes.
   typedef enum logic [1:0] {
      OP_ALLOC   = 2'd0,
      OP_RELEASE = 2'd1,
      OP_QUERY   = 2'd2
   } op_type;

   // Context mode codes.
   localparam logic [1:0] CTX_SHARED = 2'd0;
   localparam logic [1:0] CTX_REMOTE = 2'd1;
   localparam logic [1:0] CTX_SPLIT  = 2'd2;

   // Register indexes (byte address = 8 * index).
   localparam logic [1:0] REG_CONTEXT_MODE = 2'd0;
   localparam logic [1:0] REG_LOCAL_PAGE   = 2'd1;
   localparam logic [1:0] REG_REMOTE_PAGE  = 2'd2;

endpackage

// ----- rtl/csa_if.sv -----
// Request and response channel interfaces of the completion slot allocator.
interface csa_req_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   mode;
   logic                         want_remote;
   logic [csa_pkg::SLOT_W-1:0]   slot_number;

   modport source (output valid, mode, want_remote, slot_number, input ready);
   modport sink   (input valid, mode, want_remote, slot_number, output ready);
endinterface

interface csa_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         ok;
   logic [csa_pkg::SLOT_W-1:0]   granted_slot;
   logic [csa_pkg::ADDR_W-1:0]   slot_address;

   modport source (output valid, ok, granted_slot, slot_address, input ready);
   modport sink   (input valid, ok, granted_slot, slot_address, output ready);
endinterface

// ----- rtl/completion_slot_allocator.sv -----
// Completion slot allocator: two busy bitmaps with first-free allocation, release and address query.
//
// Usage:
//   req_chan carries one request per transfer: allocate (lowest free slot of the
//   local bank, or of the remote bank when want_remote is set in split context
//   mode), release (clear one busy bit) or address query (page base + 64 * offset).
//   rsp_chan returns exactly one result per request, in request order.
//   The csr_ APB port holds context_mode (0x00), local_page_iova (0x08) and
//   remote_page_iova (0x10); write them only while no request is in flight.
// Pipeline and throughput:
//   A request is captured in an input register, decoded against the busy bitmaps in
//   one pass and loaded into the result register once it is empty or draining.
//   One request per cycle is sustained while rsp_chan.ready stays high; the next
//   request sees the updated bitmaps.
// Reset:
//   Synchronous, active high. Every slot becomes free, all registers read zero,
//   and both pipeline stages empty.
// Stall:
//   When rsp_chan.ready stays low the result register holds, the input register
//   holds one more request, and req_chan.ready drops until the result drains.
module completion_slot_allocator #(
   parameter int SLOTS_PER_BANK = csa_pkg::SLOTS_PER_BANK_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   csa_req_if.sink                       req_chan,
   csa_rsp_if.source                     rsp_chan,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [csa_pkg::PADDR_W-1:0]   csr_paddr,
   input  logic [csa_pkg::DATA_W-1:0]    csr_pwdata,
   output logic [csa_pkg::DATA_W-1:0]    csr_prdata,
   output logic                          csr_pready
);

   localparam int OFF_W = csa_pkg::OFFSET_W;

   // One-hot to index over the bank; each index bit is an independent OR.
   function automatic logic [OFF_W-1:0] encode_onehot(input logic [SLOTS_PER_BANK-1:0] oh);
      logic [OFF_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < SLOTS_PER_BANK; i++) begin
         for (int b = 0; b < OFF_W; b++) begin
            if (((i >> b) & 1) == 1) begin
               idx[b] = idx[b] | oh[i];
            end
         end
      end
      return idx;
   endfunction

   // ---------------- configuration registers ----------------
   logic [1:0]                    context_mode_ff;
   logic [csa_pkg::ADDR_W-1:0]    local_page_ff;
   logic [csa_pkg::ADDR_W-1:0]    remote_page_ff;
   logic                          csr_write;
   logic [1:0]                    csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[4:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         context_mode_ff <= csa_pkg::CTX_SHARED;
         local_page_ff   <= '0;
         remote_page_ff  <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            csa_pkg::REG_CONTEXT_MODE: context_mode_ff <= csr_pwdata[1:0];
            csa_pkg::REG_LOCAL_PAGE:   local_page_ff   <= csr_pwdata;
            csa_pkg::REG_REMOTE_PAGE:  remote_page_ff  <= csr_pwdata;
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         csa_pkg::REG_CONTEXT_MODE: csr_prdata = {{(csa_pkg::DATA_W-2){1'b0}}, context_mode_ff};
         csa_pkg::REG_LOCAL_PAGE:   csr_prdata = local_page_ff;
         csa_pkg::REG_REMOTE_PAGE:  csr_prdata = remote_page_ff;
         default:                   csr_prdata = '0;
      endcase
   end

   // ---------------- input register ----------------
   logic                          req_valid_ff;
   logic [1:0]                    req_mode_ff;
   logic                          req_remote_ff;
   logic [csa_pkg::SLOT_W-1:0]    req_slot_ff;
   logic                          rsp_valid_ff;
   logic                          advance;

   // Advance the captured request when the result register is empty or draining.
   assign advance        = req_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !req_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         req_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         req_mode_ff   <= req_chan.mode;
         req_remote_ff <= req_chan.want_remote;
         req_slot_ff   <= req_chan.slot_number;
      end
   end

   // ---------------- decode against the bitmaps ----------------
   logic [SLOTS_PER_BANK-1:0]     local_busy_ff,  local_busy_in;
   logic [SLOTS_PER_BANK-1:0]     remote_busy_ff, remote_busy_in;
   logic [SLOTS_PER_BANK-1:0]     bank_free;
   logic [SLOTS_PER_BANK-1:0]     first_free;
   logic [SLOTS_PER_BANK-1:0]     release_mask;
   logic [OFF_W-1:0]              slot_offset;
   logic                          slot_is_remote;
   logic                          alloc_remote;
   logic [csa_pkg::ADDR_W-1:0]    page_base;
   logic                          ok_ff,      ok_in;
   logic [csa_pkg::SLOT_W-1:0]    granted_ff, granted_in;
   logic [csa_pkg::ADDR_W-1:0]    address_ff, address_in;

   assign slot_offset    = req_slot_ff[OFF_W-1:0];
   assign slot_is_remote = req_slot_ff[csa_pkg::SLOT_W-1];
   assign alloc_remote   = req_remote_ff && (context_mode_ff == csa_pkg::CTX_SPLIT);

   // Isolate the lowest free slot of the chosen bank.
   assign bank_free  = alloc_remote ? ~remote_busy_ff : ~local_busy_ff;
   assign first_free = bank_free & (~bank_free + 1'b1);

   // Offsets at or past the bank size match no bit, so such releases are dropped.
   always_comb begin
      for (int i = 0; i < SLOTS_PER_BANK; i++) begin
         release_mask[i] = (slot_offset == OFF_W'(i));
      end
   end

   assign page_base = (slot_is_remote || context_mode_ff == csa_pkg::CTX_REMOTE)
                      ? remote_page_ff : local_page_ff;

   always_comb begin
      local_busy_in  = local_busy_ff;
      remote_busy_in = remote_busy_ff;
      ok_in          = 1'b0;
      granted_in     = '0;
      address_in     = '0;
      unique case (req_mode_ff)
         csa_pkg::OP_ALLOC: begin
            if (bank_free != '0) begin
               ok_in      = 1'b1;
               granted_in = {alloc_remote, encode_onehot(first_free)};
               if (alloc_remote) begin
                  remote_busy_in = remote_busy_ff | first_free;
               end else begin
                  local_busy_in  = local_busy_ff | first_free;
               end
            end
         end
         csa_pkg::OP_RELEASE: begin
            ok_in = 1'b1;
            if (slot_is_remote) begin
               remote_busy_in = remote_busy_ff & ~release_mask;
            end else begin
               local_busy_in  = local_busy_ff & ~release_mask;
            end
         end
         csa_pkg::OP_QUERY: begin
            ok_in      = 1'b1;
            address_in = page_base +
                         {{(csa_pkg::ADDR_W-OFF_W-csa_pkg::ENTRY_SHIFT){1'b0}},
                          slot_offset, {csa_pkg::ENTRY_SHIFT{1'b0}}};
         end
         default: ;  // unused code: no change, all-zero result
      endcase
   end

   // ---------------- bitmaps and result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         local_busy_ff  <= '0;
         remote_busy_ff <= '0;
      end else if (advance) begin
         local_busy_ff  <= local_busy_in;
         remote_busy_ff <= remote_busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ok_ff      <= ok_in;
         granted_ff <= granted_in;
         address_ff <= address_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.ok           = ok_ff;
   assign rsp_chan.granted_slot = granted_ff;
   assign rsp_chan.slot_address = address_ff;

endmodule
